/* rtl/trdt_pkg.sv */
package trdt_pkg;

    localparam int TILE_W_DEF = 64;
    localparam int TILE_H_DEF = 32;

    localparam int DEPTH_W = 24;
    localparam int EDGE_W  = 36;
    localparam int HALF_W  = 18;
    localparam int ACC_W   = 80;

    localparam logic [1:0] KIND_BEGIN = 2'd0;
    localparam logic [1:0] KIND_TRI   = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0]          kind;
        logic signed [15:0]  vx0;
        logic signed [15:0]  vy0;
        logic signed [15:0]  vx1;
        logic signed [15:0]  vy1;
        logic signed [15:0]  vx2;
        logic signed [15:0]  vy2;
        logic [DEPTH_W-1:0]  depth_base;
        logic signed [39:0]  depth_per_beta;
        logic signed [39:0]  depth_per_gamma;
        logic [11:0]         pos_x;
        logic [11:0]         pos_y;
    } t_item;

    typedef struct packed {
        logic init_busy;
        logic take;
    } t_back_stat;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD1,
        S_RD2,
        S_SET1,
        S_SET2,
        S_PIX_A,
        S_PIX_E,
        S_PIX_T,
        S_MUL,
        S_WB
    } t_back_state;

endpackage

/* rtl/trdt_front.sv */
module trdt_front
    import trdt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_item      i_item,
    input  t_back_stat i_stat,
    output logic       o_full,
    output logic       o_valid,
    output t_item      o_item
);

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_enq, w_deq;

    assign o_full  = (r_cnt == 2'd2) || i_stat.init_busy;
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    // drop unused kind codes at the door
    assign w_enq   = i_push && !o_full && (i_item.kind != KIND_NONE);
    assign w_deq   = i_stat.take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_enq) r_wp <= ~r_wp;
            if (w_deq) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_enq} - {1'b0, w_deq};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enq) r_q[r_wp] <= i_item;
    end

endmodule

/* rtl/trdt_back.sv */
module trdt_back
    import trdt_pkg::*;
#(
    parameter int TILE_W = TILE_W_DEF,
    parameter int TILE_H = TILE_H_DEF
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_item              i_item,
    output t_back_stat         o_stat,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [DEPTH_W-1:0] o_depth_out
);

    localparam int DEPTH = TILE_W * TILE_H;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(TILE_W) + 1;
    localparam int YW    = $clog2(TILE_H) + 1;
    localparam int PW    = $clog2(4096 + TILE_W + 4) + 1;
    localparam int PRW   = 17 + PW;

    t_back_state r_state, n_state;

    logic [DEPTH_W-1:0] r_mem [DEPTH];
    logic [DEPTH_W-1:0] r_rdata;
    logic [AW-1:0]      r_addr;
    logic               r_rd_ok;
    logic               r_out_valid;
    logic [DEPTH_W-1:0] r_out;

    logic [11:0] r_ox, r_oy;
    t_item       r_it;

    logic signed [16:0]       r_a [3];
    logic signed [16:0]       r_b [3];
    logic signed [31:0]       r_m [6];
    logic signed [EDGE_W-1:0] r_c [3];
    logic signed [17:0]       r_sx, r_sy, r_ex, r_ey;
    logic [XW-1:0]            r_bsx, r_bex, r_cx;
    logic [YW-1:0]            r_bey, r_cy;
    logic [1:0]               r_i;
    logic                     r_j;
    logic signed [PRW-1:0]    r_ap [3];
    logic signed [PRW-1:0]    r_bp [3];
    logic signed [EDGE_W-1:0] r_e [3];
    logic [1:0]               r_k;
    logic signed [ACC_W-1:0]  r_acc;

    logic                     w_take, w_we, w_empty_box, w_last, w_skip, w_cover;
    logic [DEPTH_W-1:0]       w_wdata, w_nd;
    logic signed [17:0]       w_sxc, w_syc, w_exc, w_eyc;
    logic [XW-1:0]            w_lx;
    logic [YW-1:0]            w_ly;
    logic signed [PW-1:0]     w_px, w_py;
    logic [HALF_W-1:0]        w_chunk;
    logic signed [39:0]       w_d;
    logic signed [HALF_W+40:0] w_prod;
    logic signed [ACC_W-1:0]  w_term;

    assign o_empty     = !r_out_valid;
    assign o_depth_out = r_out;
    assign o_stat.init_busy = (r_state == S_CLEAR);
    assign o_stat.take      = w_take;

    // local pixel and absolute screen position
    assign w_lx = r_cx + XW'(r_i);
    assign w_ly = r_cy + YW'(r_j);
    assign w_px = $signed(PW'(r_ox) + PW'(w_lx));
    assign w_py = $signed(PW'(r_oy) + PW'(w_ly));
    assign w_skip = (32'(w_lx) >= TILE_W) || (32'(w_ly) >= TILE_H);
    assign w_last = (r_i == 2'd3) && r_j
                 && (32'(r_cx) + 4 >= 32'(r_bex)) && (32'(r_cy) + 2 >= 32'(r_bey));
    assign w_cover = !r_e[0][EDGE_W-1] && !r_e[1][EDGE_W-1] && !r_e[2][EDGE_W-1];

    // box clip
    assign w_sxc = (r_sx < 0) ? 18'sd0 : (r_sx & ~18'sd3);
    assign w_syc = (r_sy < 0) ? 18'sd0 : (r_sy & ~18'sd1);
    assign w_exc = (r_ex > 18'(TILE_W)) ? 18'(TILE_W) : r_ex;
    assign w_eyc = (r_ey > 18'(TILE_H)) ? 18'(TILE_H) : r_ey;
    assign w_empty_box = (w_exc <= w_sxc) || (w_eyc <= w_syc);

    // one partial product of the depth plane a cycle
    assign w_chunk = r_k[0] ? HALF_W'(r_e[r_k[1] ? 2 : 1][EDGE_W-1:HALF_W])
                            : r_e[r_k[1] ? 2 : 1][HALF_W-1:0];
    assign w_d     = r_k[1] ? r_it.depth_per_gamma : r_it.depth_per_beta;
    assign w_prod  = $signed({1'b0, w_chunk}) * w_d;
    assign w_term  = r_k[0] ? (ACC_W'(w_prod) <<< HALF_W) : ACC_W'(w_prod);

    assign w_nd = r_acc[ACC_W-1] ? '0
                : (r_acc[ACC_W-2:48] != '0) ? {DEPTH_W{1'b1}} : r_acc[47:24];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_addr == AW'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (w_take) begin
                    unique case (i_item.kind)
                        KIND_BEGIN: n_state = S_CLEAR;
                        KIND_TRI:   n_state = S_SET1;
                        default:    n_state = S_RD1;
                    endcase
                end
            end
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_IDLE;
            S_SET1:  n_state = S_SET2;
            S_SET2:  n_state = w_empty_box ? S_IDLE : S_PIX_A;
            S_PIX_A: n_state = w_skip ? (w_last ? S_IDLE : S_PIX_A) : S_PIX_E;
            S_PIX_E: n_state = S_PIX_T;
            S_PIX_T: n_state = w_cover ? S_MUL : (w_last ? S_IDLE : S_PIX_A);
            S_MUL:   if (r_k == 2'd3) n_state = S_WB;
            S_WB:    n_state = w_last ? S_IDLE : S_PIX_A;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_take  = 1'b0;
        w_we    = 1'b0;
        w_wdata = '0;
        unique case (r_state)
            S_IDLE:  w_take = i_valid && ((i_item.kind != KIND_READ) || !r_out_valid);
            S_CLEAR: w_we = 1'b1;
            S_WB: begin
                w_we    = (w_nd > r_rdata);
                w_wdata = w_nd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
            r_ox        <= '0;
            r_oy        <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_RD2) r_out_valid <= 1'b1;
            else if (i_pop) r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: r_addr <= r_addr + AW'(1);
                S_IDLE: begin
                    if (w_take && i_item.kind == KIND_BEGIN) begin
                        r_ox   <= i_item.pos_x;
                        r_oy   <= i_item.pos_y;
                        r_addr <= '0;
                    end else if (w_take) begin
                        r_addr <= AW'(32'(i_item.pos_y) * TILE_W + 32'(i_item.pos_x));
                    end
                end
                S_PIX_A: r_addr <= AW'(32'(w_ly) * TILE_W + 32'(w_lx));
                default: ;
            endcase
        end
    end

    // tile store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[r_addr] <= w_wdata;
        r_rdata <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_it    <= i_item;
                r_rd_ok <= (32'(i_item.pos_x) < TILE_W) && (32'(i_item.pos_y) < TILE_H);
            end
            S_RD2: r_out <= r_rd_ok ? r_rdata : '0;
            S_SET1: begin
                r_a[0] <= 17'(r_it.vy1) - 17'(r_it.vy2);
                r_a[1] <= 17'(r_it.vy2) - 17'(r_it.vy0);
                r_a[2] <= 17'(r_it.vy0) - 17'(r_it.vy1);
                r_b[0] <= 17'(r_it.vx2) - 17'(r_it.vx1);
                r_b[1] <= 17'(r_it.vx0) - 17'(r_it.vx2);
                r_b[2] <= 17'(r_it.vx1) - 17'(r_it.vx0);
                r_m[0] <= r_it.vx1 * r_it.vy2;
                r_m[1] <= r_it.vx2 * r_it.vy1;
                r_m[2] <= r_it.vx2 * r_it.vy0;
                r_m[3] <= r_it.vx0 * r_it.vy2;
                r_m[4] <= r_it.vx0 * r_it.vy1;
                r_m[5] <= r_it.vx1 * r_it.vy0;
                r_sx <= 18'(min3(r_it.vx0, r_it.vx1, r_it.vx2)) - $signed({6'd0, r_ox});
                r_sy <= 18'(min3(r_it.vy0, r_it.vy1, r_it.vy2)) - $signed({6'd0, r_oy});
                r_ex <= 18'(max3(r_it.vx0, r_it.vx1, r_it.vx2)) + 18'sd1
                        - $signed({6'd0, r_ox});
                r_ey <= 18'(max3(r_it.vy0, r_it.vy1, r_it.vy2)) + 18'sd1
                        - $signed({6'd0, r_oy});
            end
            S_SET2: begin
                r_c[0] <= EDGE_W'(r_m[0]) - EDGE_W'(r_m[1]);
                r_c[1] <= EDGE_W'(r_m[2]) - EDGE_W'(r_m[3]);
                r_c[2] <= EDGE_W'(r_m[4]) - EDGE_W'(r_m[5]);
                r_bsx <= XW'(w_sxc);
                r_bex <= XW'(w_exc);
                r_bey <= YW'(w_eyc);
                r_cx  <= XW'(w_sxc);
                r_cy  <= YW'(w_syc);
                r_i   <= 2'd0;
                r_j   <= 1'b0;
            end
            S_PIX_A: begin
                for (int k = 0; k < 3; k++) begin
                    r_ap[k] <= PRW'(r_a[k] * w_px);
                    r_bp[k] <= PRW'(r_b[k] * w_py);
                end
                if (w_skip) advance();
            end
            S_PIX_E: begin
                for (int k = 0; k < 3; k++)
                    r_e[k] <= EDGE_W'(r_ap[k]) + EDGE_W'(r_bp[k]) + r_c[k];
            end
            S_PIX_T: begin
                r_acc <= $signed({{(ACC_W-DEPTH_W-24){1'b0}}, r_it.depth_base, 24'd0});
                r_k   <= 2'd0;
                if (!w_cover) advance();
            end
            S_MUL: begin
                r_acc <= r_acc + w_term;
                r_k   <= r_k + 2'd1;
            end
            S_WB: advance();
            default: ;
        endcase
    end

    function automatic logic signed [15:0] min3(input logic signed [15:0] a, b, c);
        logic signed [15:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [15:0] max3(input logic signed [15:0] a, b, c);
        logic signed [15:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // step to the next pixel of the 4x2 block walk
    task automatic advance();
        r_i <= r_i + 2'd1;
        if (r_i == 2'd3) begin
            r_j <= ~r_j;
            if (r_j) begin
                if (32'(r_cx) + 4 >= 32'(r_bex)) begin
                    r_cx <= r_bsx;
                    r_cy <= r_cy + YW'(2);
                end else begin
                    r_cx <= r_cx + XW'(4);
                end
            end
        end
    endtask

    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !w_take)
        else $error("item taken during clear");
    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_RD2))
        else $error("result without read");
    a_edge_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PIX_E) |-> $past(r_state == S_PIX_A))
        else $error("edge sum out of order");
    a_wb_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB) |-> $past(r_state == S_MUL) && $past(r_k == 2'd3))
        else $error("write-back before products done");

endmodule

/* rtl/triangle_depth_tile_rasterizer.sv */
// Read: result registered through states RD1 and RD2; begin runs the clearing pass.
// Triangle: states SET1, SET2, then per block pixel PIX_A only if outside the tile,
// PIX_A/E/T if not covered, plus MUL and WB if covered (one 18x40 multiplier, four
// passes per pixel). Throughput is set by the pixel sequencer: one item at a time
// in the back end. Reset (synchronous, active low) starts a clearing pass of the
// depth store; full stays high until it ends. Origin resets to zero.
module triangle_depth_tile_rasterizer
    import trdt_pkg::*;
#(
    parameter int TILE_W = TILE_W_DEF,
    parameter int TILE_H = TILE_H_DEF
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [1:0]            i_kind,
    input  logic signed [15:0]    i_vx0,
    input  logic signed [15:0]    i_vy0,
    input  logic signed [15:0]    i_vx1,
    input  logic signed [15:0]    i_vy1,
    input  logic signed [15:0]    i_vx2,
    input  logic signed [15:0]    i_vy2,
    input  logic [DEPTH_W-1:0]    i_depth_base,
    input  logic signed [39:0]    i_depth_per_beta,
    input  logic signed [39:0]    i_depth_per_gamma,
    input  logic [11:0]           i_pos_x,
    input  logic [11:0]           i_pos_y,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic [DEPTH_W-1:0]    o_depth_out
);

    t_item      w_in_item, w_q_item;
    t_back_stat w_stat;
    logic       w_q_valid;

    // bundle the transaction fields
    assign w_in_item = '{kind: i_kind, vx0: i_vx0, vy0: i_vy0, vx1: i_vx1,
                         vy1: i_vy1, vx2: i_vx2, vy2: i_vy2,
                         depth_base: i_depth_base,
                         depth_per_beta: i_depth_per_beta,
                         depth_per_gamma: i_depth_per_gamma,
                         pos_x: i_pos_x, pos_y: i_pos_y};

    // front: accept, drop unused kinds, hold in a two-entry queue
    trdt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_item  (w_in_item),
        .i_stat  (w_stat),
        .o_full  (o_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    // back: clear, rasterise and read the depth tile; hold one result
    trdt_back #(
        .TILE_W (TILE_W),
        .TILE_H (TILE_H)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .i_item      (w_q_item),
        .o_stat      (w_stat),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_depth_out (o_depth_out)
    );

endmodule
